FILE: rtl/core/chuff_pkg.sv
// ----------------------------------------------------------------------------
// chuff_pkg
// shared constants, codes and types of the canonical code assignment block
// ----------------------------------------------------------------------------
package chuff_pkg;

  localparam int ALPHABET   = 512;
  localparam int MAX_LEN    = 16;

  localparam int SYM_W      = 9;
  localparam int LEN_IN_W   = 5;
  localparam int CODE_OUT_W = 16;

  localparam int ADDR_W     = $clog2(ALPHABET);
  localparam int RANK_W     = ADDR_W;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int CNT_W      = $clog2(ALPHABET + 1);
  localparam int WORD_W     = LEN_W + RANK_W;

  localparam int CODE_W0    = (MAX_LEN + 1 > CODE_OUT_W) ? MAX_LEN + 1 : CODE_OUT_W;
  localparam int CODE_W     = (CODE_W0 > CNT_W) ? CODE_W0 : CNT_W;
  localparam int SUM_W      = CODE_W + 1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FETCH = 2'd2
  } action_t;

  typedef struct packed {
    logic             clear;
    logic             drop_ready;
    logic             inc;
    logic             walk_start;
    logic [LEN_W-1:0] len;
  } tbl_ctrl_t;

  typedef struct packed {
    logic              ready;
    logic              walking;
    logic              over;
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] first_code;
  } tbl_stat_t;

endpackage

FILE: rtl/core/canonical_huffman_code_assign_top.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_assign_top
// canonical code assignment from per-symbol code lengths
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load reads the symbol ram, then writes back
// length and rank if the symbol has none yet; a load of length zero or above
// MAX_LEN, and an unknown action, leave the block idle. A fetch reads the
// symbol ram; the first fetch after a clear or a load first walks the
// lengths, one length per cycle. A fetch also waits while the output
// register holds a stalled result. A clear, and reset, run a clearing pass
// over the symbol ram, one entry per cycle, during which no item is taken.
// The symbol ram has a single read and a single write port. A finished
// result sits in the output register while the next item is taken.
module canonical_huffman_code_assign_top (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [chuff_pkg::SYM_W-1:0]     symbol,
  input  logic [chuff_pkg::LEN_IN_W-1:0]  code_len_in,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [chuff_pkg::SYM_W-1:0]     out_symbol,
  output logic [chuff_pkg::CODE_OUT_W-1:0] code_bits,
  output logic [chuff_pkg::LEN_IN_W-1:0]  code_len_out,
  output logic                            present,
  output logic                            oversubscribed
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_FETCH
  } state_t;

  state_t                        state;
  logic [chuff_pkg::ADDR_W-1:0]  sweep_addr;
  logic [chuff_pkg::ADDR_W-1:0]  addr_q;
  logic [chuff_pkg::LEN_W-1:0]   len_q;
  logic [chuff_pkg::SYM_W-1:0]   sym_q;
  logic                          in_range_q;

  chuff_pkg::action_t            act;
  logic                          accept;
  logic                          in_range;
  logic                          len_ok;
  logic                          out_free;

  logic                          mem_we;
  logic [chuff_pkg::ADDR_W-1:0]  mem_waddr;
  logic [chuff_pkg::WORD_W-1:0]  mem_wdata;
  logic                          mem_re;
  logic [chuff_pkg::WORD_W-1:0]  mem_rdata;
  logic [chuff_pkg::LEN_W-1:0]   rd_len;
  logic [chuff_pkg::RANK_W-1:0]  rd_rank;

  chuff_pkg::tbl_ctrl_t          ctl;
  chuff_pkg::tbl_stat_t          stat;

  logic [chuff_pkg::CODE_W-1:0]  code_sum;
  logic                          pres;

  assign act      = chuff_pkg::action_t'(action);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(symbol) < chuff_pkg::ALPHABET;
  assign len_ok   = (code_len_in != '0) && (32'(code_len_in) <= chuff_pkg::MAX_LEN);
  assign out_free = !out_valid || !out_stall;

  assign rd_len  = mem_rdata[chuff_pkg::WORD_W-1:chuff_pkg::RANK_W];
  assign rd_rank = mem_rdata[chuff_pkg::RANK_W-1:0];

  // symbol ram port control
  assign mem_re    = accept && (((act == chuff_pkg::ACT_LOAD) && len_ok && in_range) ||
                                (act == chuff_pkg::ACT_FETCH));
  assign mem_we    = (state == S_SWEEP) || ((state == S_LOAD) && (rd_len == '0));
  assign mem_waddr = (state == S_SWEEP) ? sweep_addr : addr_q;
  assign mem_wdata = (state == S_SWEEP) ? '0 :
                     {len_q, chuff_pkg::RANK_W'(stat.count)};

  // length table control
  assign ctl.clear      = accept && (act == chuff_pkg::ACT_CLEAR);
  assign ctl.drop_ready = accept && (act == chuff_pkg::ACT_LOAD);
  assign ctl.inc        = (state == S_LOAD) && (rd_len == '0);
  assign ctl.walk_start = accept && (act == chuff_pkg::ACT_FETCH) && !stat.ready;
  assign ctl.len        = (state == S_LOAD) ? len_q : rd_len;

  assign code_sum = stat.first_code + chuff_pkg::CODE_W'(rd_rank);
  assign pres     = in_range_q && (rd_len != '0);

  chuff_ram #(
    .DEPTH (chuff_pkg::ALPHABET),
    .WIDTH (chuff_pkg::WORD_W)
  ) u_sym_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (chuff_pkg::ADDR_W'(symbol)),
    .rdata (mem_rdata)
  );

  chuff_len_table u_len_table (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_FETCH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == chuff_pkg::ADDR_W'(chuff_pkg::ALPHABET - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr_q     <= chuff_pkg::ADDR_W'(symbol);
            len_q      <= chuff_pkg::LEN_W'(code_len_in);
            sym_q      <= symbol;
            in_range_q <= in_range;
            unique case (act)
              chuff_pkg::ACT_CLEAR: begin
                state      <= S_SWEEP;
                sweep_addr <= '0;
              end
              chuff_pkg::ACT_LOAD: begin
                if (len_ok && in_range) begin
                  state <= S_LOAD;
                end
              end
              chuff_pkg::ACT_FETCH: begin
                state <= stat.ready ? S_FETCH : S_WALK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_WALK: begin
          if (stat.ready) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (out_free) begin
            out_symbol     <= sym_q;
            code_bits      <= pres ? chuff_pkg::CODE_OUT_W'(code_sum) : '0;
            code_len_out   <= pres ? chuff_pkg::LEN_IN_W'(rd_len) : '0;
            present        <= pres;
            oversubscribed <= stat.over;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a new result only leaves the fetch state
  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FETCH))
    else $error("result raised outside fetch");

  // a fetch result is formed only from walked first codes
  a_fetch_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> stat.ready)
    else $error("fetch result formed before length walk finished");

  // a clear transfer starts the clearing pass and invalidates the codes
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (accept && (act == chuff_pkg::ACT_CLEAR)) |=> ((state == S_SWEEP) && !stat.ready))
    else $error("clear did not start clearing pass");

  // the walk runs only while a fetch waits on it
  a_walk_owner: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> (state == S_WALK))
    else $error("length walk running outside a fetch");
`endif

endmodule

FILE: rtl/core/chuff_ram.sv
// ----------------------------------------------------------------------------
// chuff_ram
// single write port, single read port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module chuff_ram #(
  parameter int  DEPTH = 512,
  parameter int  WIDTH = 14,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/chuff_len_table.sv
// ----------------------------------------------------------------------------
// chuff_len_table
// per-length symbol counts, first code per length and the length walk
// ----------------------------------------------------------------------------
module chuff_len_table (
  input  logic                 clk,
  input  logic                 rst,
  input  chuff_pkg::tbl_ctrl_t ctl,
  output chuff_pkg::tbl_stat_t stat
);

  logic [chuff_pkg::CNT_W-1:0]  len_count  [0:chuff_pkg::MAX_LEN];
  logic [chuff_pkg::CODE_W-1:0] first_code [0:chuff_pkg::MAX_LEN];

  logic                         walking;
  logic                         ready;
  logic                         over_flag;
  logic [chuff_pkg::LEN_W-1:0]  walk_l;
  logic [chuff_pkg::CODE_W-1:0] code;
  logic [chuff_pkg::CNT_W-1:0]  prev;

  logic [chuff_pkg::LEN_W-1:0]  idx;
  logic [chuff_pkg::CNT_W-1:0]  cnt_rd;
  logic [chuff_pkg::CODE_W-1:0] code_sum;
  logic [chuff_pkg::CODE_W-1:0] code_next;
  logic [chuff_pkg::SUM_W-1:0]  kraft_sum;
  logic [chuff_pkg::SUM_W-1:0]  kraft_limit;
  logic                         over_hit;

  // one read index, shared by the walk and by loads and fetches
  assign idx    = walking ? walk_l : ctl.len;
  assign cnt_rd = len_count[idx];

  assign code_sum    = code + chuff_pkg::CODE_W'(prev);
  assign code_next   = {code_sum[chuff_pkg::CODE_W-2:0], 1'b0};
  assign kraft_sum   = chuff_pkg::SUM_W'(code_next) + chuff_pkg::SUM_W'(cnt_rd);
  assign kraft_limit = chuff_pkg::SUM_W'(1) << walk_l;
  assign over_hit    = kraft_sum > kraft_limit;

  assign stat.ready      = ready;
  assign stat.walking    = walking;
  assign stat.over       = over_flag;
  assign stat.count      = cnt_rd;
  assign stat.first_code = first_code[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      walking   <= 1'b0;
      ready     <= 1'b0;
      over_flag <= 1'b0;
      for (int i = 0; i <= chuff_pkg::MAX_LEN; i++) begin
        len_count[i] <= '0;
      end
    end else if (ctl.clear) begin
      walking   <= 1'b0;
      ready     <= 1'b0;
      over_flag <= 1'b0;
      for (int i = 0; i <= chuff_pkg::MAX_LEN; i++) begin
        len_count[i] <= '0;
      end
    end else begin
      if (ctl.drop_ready) begin
        ready <= 1'b0;
      end
      if (ctl.inc) begin
        len_count[ctl.len] <= chuff_pkg::CNT_W'(cnt_rd + 1'b1);
      end
      if (ctl.walk_start) begin
        walking   <= 1'b1;
        ready     <= 1'b0;
        over_flag <= 1'b0;
        walk_l    <= chuff_pkg::LEN_W'(1);
        code      <= '0;
        prev      <= '0;
      end else if (walking) begin
        first_code[walk_l] <= code_next;
        code               <= code_next;
        prev               <= cnt_rd;
        if (over_hit) begin
          over_flag <= 1'b1;
        end
        if (walk_l == chuff_pkg::LEN_W'(chuff_pkg::MAX_LEN)) begin
          walking <= 1'b0;
          ready   <= 1'b1;
        end else begin
          walk_l <= walk_l + 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/canonical_huffman_code_assign_checker.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_assign_checker
// watches both channels of the canonical code assignment block, keeps its own
// copy of the length table and predicts every fetch result, then compares
// each delivered result field by field with the oldest open prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module canonical_huffman_code_assign_checker
  import chuff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [SYM_W-1:0]      symbol,
  input  logic [LEN_IN_W-1:0]   code_len_in,

  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SYM_W-1:0]      out_symbol,
  input  logic [CODE_OUT_W-1:0] code_bits,
  input  logic [LEN_IN_W-1:0]   code_len_out,
  input  logic                  present,
  input  logic                  oversubscribed,

  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [SYM_W-1:0]      sym;
    logic [CODE_OUT_W-1:0] bits;
    logic [LEN_IN_W-1:0]   len;
    logic                  pres;
    logic                  over;
  } code_reply_t;

  code_reply_t         open_replies[$];
  logic [LEN_IN_W-1:0] sym_len_tbl[ALPHABET];
  int unsigned         sym_rank_tbl[ALPHABET];
  int unsigned         len_tally[MAX_LEN+1];
  logic [63:0]         first_code_of[MAX_LEN+1];
  bit                  codes_current;
  bit                  kraft_broken;

  initial begin
    fail_count = 0;
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [63:0] walk_code;
    logic [63:0] walk_prev;
    logic [63:0] code;
    code_reply_t want;
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        sym_len_tbl[i]  = '0;
        sym_rank_tbl[i] = 0;
      end
      for (int l = 0; l <= MAX_LEN; l++) begin
        len_tally[l]     = 0;
        first_code_of[l] = '0;
      end
      codes_current = 1'b0;
      kraft_broken  = 1'b0;
      open_replies.delete();
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (open_replies.size() == 0) begin
          report($sformatf("result for symbol %0d with no fetch open", out_symbol));
        end else begin
          want = open_replies.pop_front();
          if (out_symbol !== want.sym)
            report($sformatf("out_symbol %0d, expected %0d", out_symbol, want.sym));
          if (code_bits !== want.bits)
            report($sformatf("symbol %0d code_bits %h, expected %h",
                             want.sym, code_bits, want.bits));
          if (code_len_out !== want.len)
            report($sformatf("symbol %0d code_len_out %0d, expected %0d",
                             want.sym, code_len_out, want.len));
          if (present !== want.pres)
            report($sformatf("symbol %0d present %b, expected %b",
                             want.sym, present, want.pres));
          if (oversubscribed !== want.over)
            report($sformatf("symbol %0d oversubscribed %b, expected %b",
                             want.sym, oversubscribed, want.over));
        end
      end

      if (in_valid && !in_stall) begin
        case (action)
          ACT_CLEAR: begin
            for (int i = 0; i < ALPHABET; i++) sym_len_tbl[i] = '0;
            for (int l = 0; l <= MAX_LEN; l++) len_tally[l] = 0;
            codes_current = 1'b0;
            kraft_broken  = 1'b0;
          end
          ACT_LOAD: begin
            codes_current = 1'b0;
            if (symbol < ALPHABET && code_len_in != 0 && code_len_in <= MAX_LEN &&
                sym_len_tbl[symbol] == 0) begin
              sym_len_tbl[symbol]    = code_len_in;
              sym_rank_tbl[symbol]   = len_tally[code_len_in];
              len_tally[code_len_in] = len_tally[code_len_in] + 1;
            end
          end
          ACT_FETCH: begin
            if (!codes_current) begin
              // first code per length, and the kraft test on the way
              walk_code        = '0;
              walk_prev        = '0;
              kraft_broken     = 1'b0;
              first_code_of[0] = '0;
              for (int l = 1; l <= MAX_LEN; l++) begin
                walk_code        = (walk_code + walk_prev) << 1;
                first_code_of[l] = walk_code;
                if (walk_code + 64'(len_tally[l]) > (64'd1 << l)) kraft_broken = 1'b1;
                walk_prev = 64'(len_tally[l]);
              end
              codes_current = 1'b1;
            end
            want      = '0;
            want.sym  = symbol;
            want.over = kraft_broken;
            if (symbol < ALPHABET && sym_len_tbl[symbol] != 0) begin
              code      = first_code_of[sym_len_tbl[symbol]] + 64'(sym_rank_tbl[symbol]);
              want.bits = code[CODE_OUT_W-1:0];
              want.len  = sym_len_tbl[symbol];
              want.pres = 1'b1;
            end
            open_replies = {open_replies, want};
          end
          default: begin
          end
        endcase
      end
    end
    pending <= open_replies.size();
  end

endmodule

FILE: tb/canonical_huffman_code_assign_top_tb.sv
// ----------------------------------------------------------------------------
// canonical_huffman_code_assign_top_tb
// drives clear, load and fetch transfers into the canonical code assignment
// block: a directed opening on the corner cases, then mostly well-formed
// tables (clear, ascending loads, fetches) mixed with random noise, under
// random sender bursts and receiver stalls; a checker compares the results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module canonical_huffman_code_assign_top_tb;
  import chuff_pkg::*;

  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam int         N_ITEMS       = 500;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         DRAIN_CYCLES  = 80;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [1:0]            action      = ACT_CLEAR;
  logic [SYM_W-1:0]      symbol      = '0;
  logic [LEN_IN_W-1:0]   code_len_in = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [SYM_W-1:0]      out_symbol;
  logic [CODE_OUT_W-1:0] code_bits;
  logic [LEN_IN_W-1:0]   code_len_out;
  logic                  present;
  logic                  oversubscribed;

  int fail_count;
  int pending;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_cycle = 0;
  int stall_hold  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  canonical_huffman_code_assign_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .symbol         (symbol),
    .code_len_in    (code_len_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .code_bits      (code_bits),
    .code_len_out   (code_len_out),
    .present        (present),
    .oversubscribed (oversubscribed)
  );

  canonical_huffman_code_assign_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .symbol         (symbol),
    .code_len_in    (code_len_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .code_bits      (code_bits),
    .code_len_out   (code_len_out),
    .present        (present),
    .oversubscribed (oversubscribed),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver stall: free, sparse random, periodic, then long runs
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= stall_cycle[1] & stall_cycle[0];
      default: begin
        if (stall_hold == 0) begin
          out_stall  <= ~out_stall;
          stall_hold <= $urandom_range(0, 20);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic [1:0] act, input int sym, input int len);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(1, 8);
    end
    in_valid    <= 1'b1;
    action      <= act;
    symbol      <= SYM_W'(sym);
    code_len_in <= LEN_IN_W'(len);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
    if (!(act == ACT_UNDEFINED || (act == ACT_LOAD && len > MAX_LEN))) items_sent++;
  endtask

  initial begin
    int n;
    int m;
    int sym;
    int len;
    int max_l;
    int kraft_used;
    int pick;
    bit over_ok;
    int loaded[$];

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, ignored loads, reorder, oversubscription, clear
    send(ACT_FETCH, 100, 0);
    send(ACT_LOAD, 0, 1);
    send(ACT_LOAD, 511, 16);
    send(ACT_LOAD, 5, 0);
    send(ACT_LOAD, 7, 17);
    send(ACT_LOAD, 9, 31);
    send(ACT_LOAD, 0, 3);
    send(ACT_FETCH, 0, 0);
    send(ACT_FETCH, 511, 0);
    send(ACT_FETCH, 5, 0);
    send(ACT_FETCH, 7, 0);
    send(ACT_LOAD, 2, 16);
    send(ACT_LOAD, 1, 16);
    send(ACT_FETCH, 1, 31);
    send(ACT_FETCH, 2, 0);
    send(ACT_UNDEFINED, 511, 31);
    send(ACT_LOAD, 3, 1);
    send(ACT_FETCH, 3, 0);
    send(ACT_FETCH, 511, 0);
    send(ACT_CLEAR, 511, 31);
    send(ACT_FETCH, 0, 0);
    send(ACT_FETCH, 511, 0);

    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // mostly well-formed table: clear, ascending loads, then fetches and stray loads
        send(ACT_CLEAR, $urandom_range(0, 511), $urandom_range(0, 31));
        loaded.delete();
        max_l      = $urandom_range(1, MAX_LEN);
        n          = $urandom_range(1, 24);
        sym        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
        kraft_used = 0;
        over_ok    = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n && sym < ALPHABET; i++) begin
          len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_l);
          if (len != 0 && !over_ok) begin
            while (len <= MAX_LEN &&
                   kraft_used + (1 << (MAX_LEN - len)) > (1 << MAX_LEN)) len++;
            if (len > MAX_LEN) break;
          end
          send(ACT_LOAD, sym, len);
          if (len != 0) begin
            loaded = {loaded, sym};
            kraft_used += 1 << (MAX_LEN - len);
          end
          sym += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) :
                                               $urandom_range(1, 3);
        end
        m = $urandom_range(3, 20);
        for (int i = 0; i < m; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send(ACT_LOAD, $urandom_range(0, 511), $urandom_range(0, MAX_LEN));
          end else if (loaded.size() > 0 && $urandom_range(0, 3) != 0) begin
            send(ACT_FETCH, loaded[$urandom_range(0, loaded.size() - 1)],
                 $urandom_range(0, 31));
          end else begin
            send(ACT_FETCH, $urandom_range(0, 511), $urandom_range(0, 31));
          end
        end
      end else begin
        // noise on top of whatever table is loaded
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 39);
          send((pick == 0) ? ACT_CLEAR : (pick < 4) ? ACT_UNDEFINED :
               (pick < 24) ? ACT_LOAD : ACT_FETCH,
               $urandom_range(0, 511), $urandom_range(0, 31));
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: canonical_huffman_code_assign_top.f
rtl/core/chuff_pkg.sv
rtl/core/chuff_ram.sv
rtl/core/chuff_len_table.sv
rtl/core/canonical_huffman_code_assign_top.sv
tb/canonical_huffman_code_assign_checker.sv
tb/canonical_huffman_code_assign_top_tb.sv
